// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level file to check this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true while out of reset.
`define KMTR_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

// Whenever ante holds, cons must hold in the same cycle.
`define KMTR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

// ===== rtl/core/kmtr_pkg.sv =====
package kmtr_pkg;

    localparam int MAX_KMER_DEF      = 8;
    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH       = 4;
    // Must be a power of two.
    localparam int REPORT_DEPTH      = 4;

    localparam logic [3:0]  KMER_LENGTH_RST = 4'd6;
    localparam logic [15:0] MIN_REPEAT_RST  = 16'd0;
    localparam logic [31:0] START_POS_RST   = 32'd0;

    localparam logic [15:0] INITIAL_COPIES = 16'd2;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_KMER_LENGTH = 2'd0,
        REG_MIN_REPEAT  = 2'd1,
        REG_START_POS   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0] base_code;
        logic       end_of_sequence;
    } base_item_t;

    typedef struct packed {
        logic [15:0] motif_index;
        logic [31:0] repeat_start;
        logic [15:0] repeat_count;
        logic [18:0] repeat_bases;
        logic [31:0] gap_bases;
        logic        first_for_motif;
        logic        last_report;
    } report_item_t;

    typedef struct packed {
        logic clearing;
        logic wbuf_collide;
    } back_status_t;

endpackage

// ===== rtl/core/kmtr_front.sv =====
module kmtr_front
    import kmtr_pkg::*;
#(
    parameter int MAX_KMER      = MAX_KMER_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int CMD_W = 2 * MAX_KMER + POSITION_BITS + $clog2(MAX_KMER + 1) + 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        kmer_length,
    input  logic [31:0]       start_position,
    input  base_item_t        item,
    input  logic              accept,
    output logic [CMD_W-1:0]  cmd
);

    localparam int WB = 2 * MAX_KMER;
    localparam int KW = $clog2(MAX_KMER + 1);
    localparam int PB = POSITION_BITS;

    typedef struct packed {
        logic [WB-1:0] idx;
        logic [PB-1:0] pos;
        logic [KW-1:0] k;
        logic          scan;
        logic          eos;
    } cmd_t;

    logic [WB-1:0] window_reg, window_next;
    logic [31:0]   bases_seen_reg, bases_seen_next;
    logic [KW-1:0] k_eff;
    logic [WB+1:0] window_cat;
    logic [WB-1:0] window_shift;
    logic [WB-1:0] kmer_mask;
    logic [31:0]   k_minus_one;
    logic [33:0]   pos_sum;
    cmd_t          c;

    always_comb
    begin
        if (kmer_length == 4'd0)
        begin
            k_eff = KW'(1);
        end
        else if (kmer_length > 4'(MAX_KMER))
        begin
            k_eff = KW'(MAX_KMER);
        end
        else
        begin
            k_eff = kmer_length[KW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_KMER; i++)
        begin
            kmer_mask[2*i +: 2] = {2{(i < int'(k_eff))}};
        end
    end

    assign window_cat   = {window_reg, item.base_code};
    assign window_shift = window_cat[WB-1:0];
    assign k_minus_one  = 32'(k_eff) - 32'd1;
    // The k-mer ending on this base starts k-1 bases earlier.
    assign pos_sum      = 34'(start_position) + 34'(bases_seen_reg) - 34'(k_minus_one);

    always_comb
    begin
        c.idx  = window_shift & kmer_mask;
        c.pos  = PB'(pos_sum);
        c.k    = k_eff;
        c.scan = (bases_seen_reg >= k_minus_one);
        c.eos  = item.end_of_sequence;
    end

    assign cmd = c;

    always_comb
    begin
        window_next     = window_reg;
        bases_seen_next = bases_seen_reg;
        if (accept)
        begin
            if (item.end_of_sequence)
            begin
                window_next     = '0;
                bases_seen_next = '0;
            end
            else
            begin
                window_next = window_shift;
                if (bases_seen_reg != 32'hFFFF_FFFF)
                begin
                    bases_seen_next = bases_seen_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            bases_seen_reg <= '0;
        end
        else
        begin
            window_reg     <= window_next;
            bases_seen_reg <= bases_seen_next;
        end
    end

endmodule

// ===== rtl/core/kmtr_queue.sv =====
module kmtr_queue
    import kmtr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : PW'(tail_reg + 1'b1);
        end
        if (pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : PW'(head_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/kmtr_back.sv =====
module kmtr_back
    import kmtr_pkg::*;
#(
    parameter int MAX_KMER      = MAX_KMER_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int CMD_W = 2 * MAX_KMER + POSITION_BITS + $clog2(MAX_KMER + 1) + 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      min_repeat_length,
    input  logic [CMD_W-1:0] head_cmd,
    input  logic             head_valid,
    output logic             pop,
    output back_status_t     status,
    output logic             report_valid,
    input  logic             report_stall,
    output report_item_t     report_item
);

    localparam int WB  = 2 * MAX_KMER;
    localparam int KW  = $clog2(MAX_KMER + 1);
    localparam int PB  = POSITION_BITS;
    localparam int BW  = 16 + KW;
    localparam int CW  = ((PB > BW) ? PB : BW) + 1;
    localparam int TABLE_DEPTH = 1 << WB;
    localparam int RPW = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
    localparam int RCW = $clog2(REPORT_DEPTH + 1);

    typedef struct packed {
        logic [WB-1:0] idx;
        logic [PB-1:0] pos;
        logic [KW-1:0] k;
        logic          scan;
        logic          eos;
    } cmd_t;

    typedef struct packed {
        logic          seen;
        logic          in_run;
        logic [PB-1:0] last;
    } a_entry_t;

    typedef struct packed {
        logic          has;
        logic [PB-1:0] prev;
    } b_entry_t;

    function automatic report_item_t make_report(input logic [WB-1:0] m,
                                                 input logic [PB-1:0] s,
                                                 input logic [15:0] cnt,
                                                 input logic [BW-1:0] bases,
                                                 input b_entry_t b);
        report_item_t r;
        logic [PB-1:0] diff;
        diff = (s >= b.prev) ? (s - b.prev) : (b.prev - s);
        r.motif_index     = 16'(m);
        r.repeat_start    = 32'(s);
        r.repeat_count    = cnt;
        r.repeat_bases    = 19'(bases);
        r.gap_bases       = b.has ? 32'(diff) : 32'd0;
        r.first_for_motif = !b.has;
        r.last_report     = 1'b0;
        return r;
    endfunction

    function automatic logic [PB-1:0] repeat_end(input logic [PB-1:0] s,
                                                 input logic [BW-1:0] bases);
        return PB'(s + PB'(bases) - 1'b1);
    endfunction

    // Motif tables: run state on one memory, last repeat end on the other.
    a_entry_t mem_a [TABLE_DEPTH];
    b_entry_t mem_b [TABLE_DEPTH];

    a_entry_t rd_a_reg;
    b_entry_t rd_b_reg;
    logic [WB-1:0] rd_addr;

    logic          clr_active_reg, clr_active_next;
    logic [WB-1:0] clr_addr_reg, clr_addr_next;

    logic          e_valid_reg, e_valid_next;
    cmd_t          e_cmd_reg, e_cmd_next;
    cmd_t          c;
    cmd_t          h;

    logic          la_valid_reg;
    logic [WB-1:0] la_addr_reg;
    a_entry_t      la_data_reg;
    logic          lb_valid_reg;
    logic [WB-1:0] lb_addr_reg;
    b_entry_t      lb_data_reg;
    logic          wbuf_valid_reg, wbuf_valid_next;
    logic [WB-1:0] wbuf_addr_reg, wbuf_addr_next;
    b_entry_t      wbuf_data_reg, wbuf_data_next;

    logic          a_we;
    logic [WB-1:0] a_waddr;
    a_entry_t      a_wdata;
    logic          b_we;
    logic [WB-1:0] b_waddr;
    b_entry_t      b_wdata;

    logic          pv_reg, pv_next;
    logic [PB-1:0] ps_reg, ps_next;
    logic [WB-1:0] pm_reg, pm_next;
    logic [15:0]   pc_reg, pc_next;
    b_entry_t      pb_ent_reg, pb_ent_next;

    logic          advance;
    logic          room;
    a_entry_t      ea;
    b_entry_t      eb;
    logic [BW-1:0] bases0, bases1;
    logic          dist_hit, in_other, not_seen, brk, supp, ext, start;
    logic          emit1, emit2;
    report_item_t  rep1, rep2;
    b_entry_t      newb1, newb2;
    logic          pv1;
    logic [PB-1:0] ps1;
    logic [WB-1:0] pm1;
    logic [15:0]   pc1;
    b_entry_t      pent1;

    report_item_t  rf_mem [REPORT_DEPTH];
    logic [RPW-1:0] rf_head_reg, rf_head_next;
    logic [RPW-1:0] rf_tail_reg, rf_tail_next;
    logic [RCW-1:0] rf_count_reg, rf_count_next;
    logic           rf_pop;
    logic [1:0]     n_push;
    report_item_t   rec0, rec1;

    assign c = e_cmd_reg;
    assign h = head_cmd;

    // Two free report slots cover the worst case of one item.
    assign room    = (rf_count_reg <= RCW'(REPORT_DEPTH - 2));
    assign advance = e_valid_reg && room && !clr_active_reg;
    assign pop     = head_valid && (!e_valid_reg || advance) && !clr_active_reg;
    assign rd_addr = pop ? h.idx : c.idx;

    always_comb
    begin
        e_valid_next = e_valid_reg;
        e_cmd_next   = e_cmd_reg;
        if (pop)
        begin
            e_valid_next = 1'b1;
            e_cmd_next   = h;
        end
        else if (advance)
        begin
            e_valid_next = 1'b0;
        end
    end

    // Read data misses the write of the same edge, so the last writes forward.
    always_comb
    begin
        ea = (la_valid_reg && la_addr_reg == c.idx) ? la_data_reg : rd_a_reg;
        if (wbuf_valid_reg && wbuf_addr_reg == c.idx)
        begin
            eb = wbuf_data_reg;
        end
        else if (lb_valid_reg && lb_addr_reg == c.idx)
        begin
            eb = lb_data_reg;
        end
        else
        begin
            eb = rd_b_reg;
        end
    end

    always_comb
    begin
        bases0   = BW'(pc_reg) * BW'(c.k);
        dist_hit = (PB'(c.pos - ea.last) == PB'(c.k));
        in_other = pv_reg && (c.idx != pm_reg) &&
                   ((CW'(ea.last) + CW'(c.k)) < (CW'(ps_reg) + CW'(bases0)));
        not_seen = c.scan && !ea.seen;
        brk      = c.scan && ea.seen && !dist_hit;
        supp     = c.scan && ea.seen && dist_hit && in_other;
        ext      = c.scan && ea.seen && dist_hit && !in_other && ea.in_run &&
                   pv_reg && (c.idx == pm_reg);
        start    = c.scan && ea.seen && dist_hit && !in_other && !ext;

        emit1 = start && pv_reg && (bases0 >= BW'(min_repeat_length));
        rep1  = make_report(pm_reg, ps_reg, pc_reg, bases0, pb_ent_reg);
        newb1.has  = 1'b1;
        newb1.prev = repeat_end(ps_reg, bases0);

        pv1   = pv_reg;
        ps1   = ps_reg;
        pm1   = pm_reg;
        pc1   = pc_reg;
        pent1 = pb_ent_reg;
        if (start)
        begin
            pv1 = 1'b1;
            ps1 = ea.last;
            pm1 = c.idx;
            pc1 = INITIAL_COPIES;
            // The report just made may belong to the same motif.
            pent1 = (emit1 && pm_reg == c.idx) ? newb1 : eb;
        end
        else if (ext)
        begin
            if (pc_reg != COUNT_MAX)
            begin
                pc1 = pc_reg + 16'd1;
            end
        end

        bases1 = BW'(pc1) * BW'(c.k);
        emit2  = c.eos && pv1 && (bases1 >= BW'(min_repeat_length));
        rep2   = make_report(pm1, ps1, pc1, bases1, pent1);
        newb2.has  = 1'b1;
        newb2.prev = repeat_end(ps1, bases1);
    end

    always_comb
    begin
        pv_next     = pv_reg;
        ps_next     = ps_reg;
        pm_next     = pm_reg;
        pc_next     = pc_reg;
        pb_ent_next = pb_ent_reg;
        if (advance)
        begin
            pv_next     = pv1 && !c.eos;
            ps_next     = ps1;
            pm_next     = pm1;
            pc_next     = pc1;
            pb_ent_next = pent1;
        end
    end

    always_comb
    begin
        a_wdata.seen = 1'b1;
        a_wdata.last = c.pos;
        if (not_seen)
        begin
            a_wdata.in_run = ea.in_run;
        end
        else if (brk || supp)
        begin
            a_wdata.in_run = 1'b0;
        end
        else
        begin
            a_wdata.in_run = 1'b1;
        end
        a_we    = advance && c.scan;
        a_waddr = c.idx;
        if (clr_active_reg)
        begin
            a_we    = 1'b1;
            a_waddr = clr_addr_reg;
            a_wdata = '0;
        end
    end

    // A flush report's table write is held in a buffer; a new sequence cannot report at once.
    always_comb
    begin
        b_we            = 1'b0;
        b_waddr         = wbuf_addr_reg;
        b_wdata         = wbuf_data_reg;
        wbuf_valid_next = wbuf_valid_reg;
        wbuf_addr_next  = wbuf_addr_reg;
        wbuf_data_next  = wbuf_data_reg;
        if (clr_active_reg)
        begin
            b_we    = 1'b1;
            b_waddr = clr_addr_reg;
            b_wdata = '0;
        end
        else if (advance && emit1)
        begin
            b_we    = 1'b1;
            b_waddr = pm_reg;
            b_wdata = newb1;
        end
        else if (wbuf_valid_reg)
        begin
            b_we            = 1'b1;
            wbuf_valid_next = 1'b0;
        end
        if (advance && emit2)
        begin
            wbuf_valid_next = 1'b1;
            wbuf_addr_next  = pm1;
            wbuf_data_next  = newb2;
        end
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = WB'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == '1)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_waddr] <= a_wdata;
        end
        rd_a_reg <= mem_a[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[b_waddr] <= b_wdata;
        end
        rd_b_reg <= mem_b[rd_addr];
    end

    // Report queue: up to two pushes and one pop per cycle.
    always_comb
    begin
        n_push = 2'd0;
        rec0   = rep1;
        rec1   = rep2;
        if (advance)
        begin
            n_push = 2'(emit1) + 2'(emit2);
        end
        if (emit1 && emit2)
        begin
            rec1.last_report = 1'b1;
        end
        else
        begin
            rec0 = emit1 ? rep1 : rep2;
            rec0.last_report = 1'b1;
        end
    end

    assign report_valid = (rf_count_reg != '0);
    assign report_item  = rf_mem[rf_head_reg];
    assign rf_pop       = report_valid && !report_stall;

    always_comb
    begin
        rf_tail_next  = RPW'(rf_tail_reg + RPW'(n_push));
        rf_head_next  = rf_pop ? RPW'(rf_head_reg + 1'b1) : rf_head_reg;
        rf_count_next = RCW'(rf_count_reg + RCW'(n_push) - RCW'(rf_pop));
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            rf_mem[rf_tail_reg] <= rec0;
        end
        if (n_push == 2'd2)
        begin
            rf_mem[RPW'(rf_tail_reg + 1'b1)] <= rec1;
        end
    end

    always_ff @(posedge clk)
    begin
        e_cmd_reg     <= e_cmd_next;
        la_addr_reg   <= a_waddr;
        la_data_reg   <= a_wdata;
        lb_addr_reg   <= b_waddr;
        lb_data_reg   <= b_wdata;
        wbuf_addr_reg <= wbuf_addr_next;
        wbuf_data_reg <= wbuf_data_next;
        ps_reg        <= ps_next;
        pm_reg        <= pm_next;
        pc_reg        <= pc_next;
        pb_ent_reg    <= pb_ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            e_valid_reg    <= 1'b0;
            la_valid_reg   <= 1'b0;
            lb_valid_reg   <= 1'b0;
            wbuf_valid_reg <= 1'b0;
            pv_reg         <= 1'b0;
            rf_head_reg    <= '0;
            rf_tail_reg    <= '0;
            rf_count_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            e_valid_reg    <= e_valid_next;
            la_valid_reg   <= a_we;
            lb_valid_reg   <= b_we;
            wbuf_valid_reg <= wbuf_valid_next;
            pv_reg         <= pv_next;
            rf_head_reg    <= rf_head_next;
            rf_tail_reg    <= rf_tail_next;
            rf_count_reg   <= rf_count_next;
        end
    end

    assign status.clearing     = clr_active_reg;
    assign status.wbuf_collide = advance && emit1 && wbuf_valid_reg;

endmodule

// ===== rtl/core/kmer_tandem_repeat_finder.sv =====
// Channel   Direction  Handshake                      Payload
// base      in         base_valid / base_stall        base_item (base_item_t)
// report    out        report_valid / report_stall    report_item (report_item_t)
// config    in         APB psel/penable/pwrite        paddr, pwdata, prdata
//
// One base is taken per cycle while base_stall is low; a base is registered in
// the queue, then in the back stage, and its reports wait in the report queue.
// The back stage does one motif table read-modify-write per base, with
// forwarding of the last writes, and that loop sets the rate.
// After reset a clearing pass runs over all 4**MAX_KMER entries of the motif
// tables (65536 by default); base_stall stays high meanwhile.
// The back stage holds a base while fewer than two report slots are free.
module kmer_tandem_repeat_finder
    import kmtr_pkg::*;
#(
    parameter int MAX_KMER      = MAX_KMER_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         base_valid,
    output logic         base_stall,
    input  base_item_t   base_item,
    output logic         report_valid,
    input  logic         report_stall,
    output report_item_t report_item,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    `include "assert_macros.svh"

    localparam int CMD_W = 2 * MAX_KMER + POSITION_BITS + $clog2(MAX_KMER + 1) + 2;

    logic [3:0]  kmer_length_reg, kmer_length_next;
    logic [15:0] min_repeat_reg, min_repeat_next;
    logic [31:0] start_pos_reg, start_pos_next;
    logic        cfg_write;
    reg_index_t  cfg_index;

    logic             accept;
    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] head_cmd;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    back_status_t     back_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        kmer_length_next = kmer_length_reg;
        min_repeat_next  = min_repeat_reg;
        start_pos_next   = start_pos_reg;
        prdata           = 32'd0;
        unique case (cfg_index)
            REG_KMER_LENGTH:
            begin
                prdata = {28'd0, kmer_length_reg};
                if (cfg_write)
                begin
                    kmer_length_next = pwdata[3:0];
                end
            end
            REG_MIN_REPEAT:
            begin
                prdata = {16'd0, min_repeat_reg};
                if (cfg_write)
                begin
                    min_repeat_next = pwdata[15:0];
                end
            end
            REG_START_POS:
            begin
                prdata = start_pos_reg;
                if (cfg_write)
                begin
                    start_pos_next = pwdata;
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_LENGTH_RST;
            min_repeat_reg  <= MIN_REPEAT_RST;
            start_pos_reg   <= START_POS_RST;
        end
        else
        begin
            kmer_length_reg <= kmer_length_next;
            min_repeat_reg  <= min_repeat_next;
            start_pos_reg   <= start_pos_next;
        end
    end

    assign base_stall = q_full || back_status.clearing;
    assign accept     = base_valid && !base_stall;

    kmtr_front #(
        .MAX_KMER      (MAX_KMER),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .kmer_length    (kmer_length_reg),
        .start_position (start_pos_reg),
        .item           (base_item),
        .accept         (accept),
        .cmd            (front_cmd)
    );

    kmtr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head_data (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    kmtr_back #(
        .MAX_KMER      (MAX_KMER),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .min_repeat_length (min_repeat_reg),
        .head_cmd          (head_cmd),
        .head_valid        (!q_empty),
        .pop               (q_pop),
        .status            (back_status),
        .report_valid      (report_valid),
        .report_stall      (report_stall),
        .report_item       (report_item)
    );

    // A held flush write must drain before the next report of a sequence.
    `KMTR_ASSERT_NEVER(a_wbuf_collide, clk, rst_n, back_status.wbuf_collide)
    // No transaction moves into the back stage during the clearing pass.
    `KMTR_ASSERT_IMPLY(a_no_pop_clear, clk, rst_n, back_status.clearing, !q_pop)
    // The queue is never pushed past its depth.
    `KMTR_ASSERT_NEVER(a_queue_overrun, clk, rst_n, accept && q_full && !q_pop)

endmodule
